FILE: sv/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the six-channel moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int WINDOW      = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int NCHAN       = 6;
    localparam int OUT_BITS    = 24;

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + PTR_W;
    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int ROW_W  = NCHAN * SAMPLE_BITS;

    typedef logic [NCHAN-1:0][SAMPLE_BITS-1:0] t_row;
    typedef logic [NCHAN-1:0][SUM_W-1:0]       t_sums;
    typedef logic [NCHAN-1:0][OUT_BITS-1:0]    t_quots;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] avg_accel_x;
        logic signed [OUT_BITS-1:0] avg_accel_y;
        logic signed [OUT_BITS-1:0] avg_accel_z;
        logic signed [OUT_BITS-1:0] avg_gyro_x;
        logic signed [OUT_BITS-1:0] avg_gyro_y;
        logic signed [OUT_BITS-1:0] avg_gyro_z;
        logic                       window_full;
    } t_out;

endpackage

FILE: sv/sma_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_ring
// Sample ring: one row of six samples per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module sma_ring (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [sma_pkg::PTR_W-1:0] i_wr_addr,
    input  sma_pkg::t_row             i_wr_data,
    input  logic                      i_rd_en,
    input  logic [sma_pkg::PTR_W-1:0] i_rd_addr,
    output sma_pkg::t_row             o_rd_data
);

    logic [sma_pkg::ROW_W-1:0] mem [sma_pkg::WINDOW];
    logic [sma_pkg::ROW_W-1:0] r_rd_data;

    // write the new row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read the oldest row through a registered port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/sma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_div
// Bit-serial signed divider, six lanes sharing one step counter.
// Computes (sum * 2^FRAC_BITS) / divisor, truncated toward zero.
// ----------------------------------------------------------------------------
module sma_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  sma_pkg::t_sums             i_sums,
    input  logic [sma_pkg::FILL_W-1:0] i_divisor,
    output logic                       o_done,
    output sma_pkg::t_quots            o_quots
);

    logic [sma_pkg::NCHAN-1:0][sma_pkg::DIVD_W-1:0] r_q;
    logic [sma_pkg::NCHAN-1:0][sma_pkg::FILL_W-1:0] r_rem;
    logic [sma_pkg::NCHAN-1:0]                      r_neg;
    logic [sma_pkg::FILL_W-1:0]                     r_div;
    logic [sma_pkg::CNT_W-1:0]                      r_cnt;
    logic                                           r_busy;
    logic                                           r_done;

    // control: count one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == sma_pkg::CNT_W'(sma_pkg::DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath lanes: load magnitude, then shift and subtract
    for (genvar c = 0; c < sma_pkg::NCHAN; c++) begin : g_lane
        logic [sma_pkg::SUM_W-1:0]  mag;
        logic [sma_pkg::FILL_W:0]   rem_sh;
        logic                       ge;
        logic [sma_pkg::DIVD_W-1:0] q_signed;

        assign mag    = i_sums[c][sma_pkg::SUM_W-1] ? (~i_sums[c] + 1'b1) : i_sums[c];
        assign rem_sh = {r_rem[c], r_q[c][sma_pkg::DIVD_W-1]};
        assign ge     = rem_sh >= {1'b0, r_div};

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_q[c]   <= {mag, {sma_pkg::FRAC_BITS{1'b0}}};
                r_rem[c] <= '0;
                r_neg[c] <= i_sums[c][sma_pkg::SUM_W-1];
            end else if (r_busy) begin
                r_q[c]   <= {r_q[c][sma_pkg::DIVD_W-2:0], ge};
                r_rem[c] <= ge ? sma_pkg::FILL_W'(rem_sh - {1'b0, r_div})
                               : rem_sh[sma_pkg::FILL_W-1:0];
            end
        end

        // restore the sign; the mean always fits the output width
        assign q_signed   = r_neg[c] ? (~r_q[c] + 1'b1) : r_q[c];
        assign o_quots[c] = q_signed[sma_pkg::OUT_BITS-1:0];
    end

    // hold the divisor for the whole run
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;

endmodule

FILE: sv/six_channel_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_channel_moving_average
// Boxcar mean over six signed sensor channels, with a ring of the last
// WINDOW sample rows and one running sum per channel.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (t_in)
//  output   | o_out_valid  | i_out_stall  | o_out_data (t_out)
//
//  From acceptance to result, a request passes through the ring read and
//  sum update, then the bit-serial divider (one quotient bit per cycle,
//  all six lanes at once), then the output register. Reset clears the
//  sums, ring pointer and fill count; the ring itself is not cleared. A
//  finished result waits in the output register while the next request
//  is accepted and worked on.
// ----------------------------------------------------------------------------
module six_channel_moving_average (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sma_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sma_pkg::t_out o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    sma_pkg::t_in               r_in;
    logic [sma_pkg::PTR_W-1:0]  r_ptr, n_ptr;
    logic [sma_pkg::FILL_W-1:0] r_fill, n_fill;
    sma_pkg::t_sums             r_sum, n_sum;
    sma_pkg::t_out              r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic            in_acc;
    logic            out_free;
    logic            was_full;
    logic            load_out;
    sma_pkg::t_row   new_row;
    sma_pkg::t_row   old_row;
    logic            div_done;
    sma_pkg::t_quots quots;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign was_full = r_fill == sma_pkg::FILL_W'(sma_pkg::WINDOW);

    // unpack the held request into a sample row
    assign new_row = {r_in.accel_x, r_in.accel_y, r_in.accel_z,
                      r_in.gyro_x, r_in.gyro_y, r_in.gyro_z};

    sma_ring u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_ptr),
        .i_wr_data (new_row),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_ptr),
        .o_rd_data (old_row)
    );

    // new sums: add the new sample, drop the oldest once the window is full
    always_comb begin
        for (int c = 0; c < sma_pkg::NCHAN; c++) begin
            n_sum[c] = r_sum[c]
                     + sma_pkg::SUM_W'($signed(new_row[c]))
                     - (was_full ? sma_pkg::SUM_W'($signed(old_row[c])) : '0);
        end
    end

    // advance pointer and fill count
    assign n_ptr  = (r_ptr == sma_pkg::PTR_W'(sma_pkg::WINDOW - 1)) ? '0 : r_ptr + 1'b1;
    assign n_fill = was_full ? r_fill : r_fill + 1'b1;

    sma_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_UPD),
        .i_sums    (n_sum),
        .i_divisor (n_fill),
        .o_done    (div_done),
        .o_quots   (quots)
    );

    // sequence one request at a time
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

    // build the result from the divider lanes
    always_comb begin
        n_out.avg_accel_x = quots[5];
        n_out.avg_accel_y = quots[4];
        n_out.avg_accel_z = quots[3];
        n_out.avg_gyro_x  = quots[2];
        n_out.avg_gyro_y  = quots[1];
        n_out.avg_gyro_z  = quots[0];
        n_out.window_full = was_full;
    end

    // output register valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_UPD) begin
                r_ptr  <= n_ptr;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
